// ===== sv/wpcm_pkg.sv =====
package wpcm_pkg;

   localparam int MAX_SAMPLE_BYTES = 8;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [2:0] CSR_FORMAT_KIND    = 3'd0;
   localparam logic [2:0] CSR_CONTAINER_BITS = 3'd1;
   localparam logic [2:0] CSR_SIG_BITS       = 3'd2;
   localparam logic [2:0] CSR_CHANNEL_COUNT  = 3'd3;
   localparam logic [2:0] CSR_FRAME_BYTES    = 3'd4;

   localparam logic [1:0] FMT_INT   = 2'd0;
   localparam logic [1:0] FMT_FLOAT = 2'd1;

   // conversion classes decided by the front
   localparam logic [2:0] CLS_ERROR = 3'd0;
   localparam logic [2:0] CLS_U8    = 3'd1;
   localparam logic [2:0] CLS_S16   = 3'd2;
   localparam logic [2:0] CLS_S24   = 3'd3;
   localparam logic [2:0] CLS_S32   = 3'd4;
   localparam logic [2:0] CLS_F32   = 3'd5;
   localparam logic [2:0] CLS_F64   = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_end;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic [15:0]        channel_index;
      logic               status;
   } rsp_word_type;

   // one gathered sample handed from front to back
   typedef struct packed {
      logic [63:0] sample_word;
      logic [2:0]  sample_class;
      logic [15:0] channel_index;
      logic [6:0]  sig_bits;
   } job_type;

endpackage

// ===== sv/wpcm_front.sv =====
module wpcm_front #(
   parameter int MaxSampleBytes = wpcm_pkg::MAX_SAMPLE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  wpcm_pkg::req_word_type req_word,
   input  logic [1:0]            format_kind,
   input  logic [6:0]            container_bits,
   input  logic [6:0]            sig_bits,
   input  logic [15:0]           channel_count,
   input  logic [15:0]           frame_bytes,
   output logic                  job_valid,
   output wpcm_pkg::job_type     job
);
   localparam int WordBits = MaxSampleBytes * 8;

   logic [15:0] frame_position_ff, frame_position_in;
   logic [WordBits-1:0] sample_word_ff, sample_word_in, merged;
   logic [2:0]  byte_in_sample_ff, byte_in_sample_in;
   logic [15:0] channel_counter_ff, channel_counter_in;

   logic [4:0]  bps;
   logic [3:0]  walk;
   logic        active, done, frame_end, size_bad;
   logic [19:0] tight;
   logic [2:0]  cls;
   logic [5:0]  shamt;

   assign bps = 5'(({1'b0, container_bits} + 8'd7) >> 3);
   assign walk = (bps == 5'd0) ? 4'd1 :
                 (bps > 5'(MaxSampleBytes)) ? 4'(MaxSampleBytes) : bps[3:0];
   assign tight = 20'(channel_count) * 20'(bps);
   assign size_bad = (bps == 5'd0) || (bps > 5'(MaxSampleBytes)) ||
                     (channel_count == 16'd0) || (20'(frame_bytes) < tight);

   always_comb begin
      cls = wpcm_pkg::CLS_ERROR;
      if (size_bad) begin
         cls = wpcm_pkg::CLS_ERROR;
      end else if (format_kind == wpcm_pkg::FMT_FLOAT) begin
         if (container_bits == 7'd32) cls = wpcm_pkg::CLS_F32;
         else if (container_bits == 7'd64) cls = wpcm_pkg::CLS_F64;
      end else if (format_kind == wpcm_pkg::FMT_INT && sig_bits != 7'd0) begin
         if (sig_bits <= 7'd8) cls = wpcm_pkg::CLS_U8;
         else if (sig_bits <= 7'd16 && bps == 5'd2) cls = wpcm_pkg::CLS_S16;
         else if (sig_bits <= 7'd24 && bps == 5'd3) cls = wpcm_pkg::CLS_S24;
         else if (sig_bits <= 7'd32 && bps == 5'd4) cls = wpcm_pkg::CLS_S32;
      end
   end

   assign active = channel_counter_ff < channel_count;
   assign shamt = {byte_in_sample_ff, 3'b000};
   assign merged = sample_word_ff | (WordBits'(req_word.data_byte) << shamt);
   assign done = active && ({1'b0, byte_in_sample_ff} + 4'd1 >= walk);
   assign frame_end = (17'(frame_position_ff) + 17'd1 >= 17'(frame_bytes));

   always_comb begin
      frame_position_in  = frame_position_ff;
      sample_word_in     = sample_word_ff;
      byte_in_sample_in  = byte_in_sample_ff;
      channel_counter_in = channel_counter_ff;
      if (take) begin
         if (active) begin
            if (done) begin
               sample_word_in = '0;
               byte_in_sample_in = '0;
               channel_counter_in = channel_counter_ff + 16'd1;
            end else begin
               sample_word_in = merged;
               byte_in_sample_in = byte_in_sample_ff + 3'd1;
            end
         end
         if (frame_end || req_word.chunk_end) begin
            frame_position_in = '0;
            channel_counter_in = '0;
            byte_in_sample_in = '0;
            sample_word_in = '0;
         end else begin
            frame_position_in = frame_position_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_position_ff  <= '0;
         sample_word_ff     <= '0;
         byte_in_sample_ff  <= '0;
         channel_counter_ff <= '0;
      end else begin
         frame_position_ff  <= frame_position_in;
         sample_word_ff     <= sample_word_in;
         byte_in_sample_ff  <= byte_in_sample_in;
         channel_counter_ff <= channel_counter_in;
      end
   end

   assign job_valid = take && done;
   assign job.sample_word = 64'(merged);
   assign job.sample_class = cls;
   assign job.channel_index = channel_counter_ff;
   assign job.sig_bits = sig_bits;
endmodule

// ===== sv/wpcm_queue.sv =====
module wpcm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wpcm_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output wpcm_pkg::job_type pop_job,
   input  logic              pop
);
   // four-entry queue; front only stalls when no free slot
   wpcm_pkg::job_type mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] count_ff;

   assign full = (count_ff == 3'd4);
   assign pop_valid = (count_ff != 3'd0);
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         count_ff <= count_ff + {2'b00, push} - {2'b00, pop};
      end
   end
endmodule

// ===== sv/wpcm_back.sv =====
module wpcm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  wpcm_pkg::job_type      job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wpcm_pkg::rsp_word_type rsp_word
);
   // stage 1: integer paths resolved, float split up and mantissa * 32767
   // stage 2: product rounded to double precision, then shifted
   logic        s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic        s1_is_float_ff, s1_err_ff, s1_zero_ff, s1_neg1_ff, s1_sat_ff, s1_sign_ff;
   logic [15:0] s1_int_ff, s1_chan_ff;
   logic [67:0] s1_prod_ff;
   logic [5:0]  s1_shift_ff;
   logic        s2_err_ff;
   logic [15:0] s2_pcm_ff, s2_chan_ff;
   wpcm_pkg::rsp_word_type out_ff;

   logic advance;
   assign advance = !out_valid_ff || !rsp_stall;
   assign job_pop = job_valid && advance;

   // stage 1 combinational
   logic [63:0] w;
   logic [31:0] v32, sh32;
   logic [15:0] int_res, sat_res;
   logic        is_float, err, zero, neg1, sat1, sgn;
   logic [52:0] mant;
   logic [67:0] prod;
   logic [5:0]  shift;
   logic signed [12:0] e;
   logic [4:0]  k;

   always_comb begin
      w = job.sample_word;
      v32 = 32'(w[31:0]);
      if (job.sample_class == wpcm_pkg::CLS_S24) v32 = {{8{w[23]}}, w[23:0]};
      if (v32[31] && v32 < 32'hFFFF8000) sat_res = 16'h8000;
      else if (!v32[31] && v32 > 32'h7FFF) sat_res = 16'h7FFF;
      else sat_res = v32[15:0];
      k = 5'(job.sig_bits - 7'd16);
      sh32 = 32'($signed(v32) >>> k);
      int_res = '0; is_float = 1'b0; err = 1'b0; zero = 1'b0; neg1 = 1'b0;
      sat1 = 1'b0; sgn = 1'b0; mant = '0; shift = '0; e = '0;
      case (job.sample_class)
         wpcm_pkg::CLS_U8:  int_res = {w[7:0] ^ 8'h80, 8'h00};
         wpcm_pkg::CLS_S16: int_res = w[15:0];
         wpcm_pkg::CLS_S24, wpcm_pkg::CLS_S32:
            int_res = (job.sig_bits <= 7'd16) ? sat_res : sh32[15:0];
         wpcm_pkg::CLS_F32: begin
            is_float = 1'b1;
            sgn = w[31];
            e = 13'($signed({5'd0, w[30:23]})) - 13'sd127;
            mant = {1'b1, w[22:0], 29'd0};
            zero = (w[30:23] == 8'hFF);
         end
         wpcm_pkg::CLS_F64: begin
            is_float = 1'b1;
            sgn = w[63];
            e = 13'($signed({2'd0, w[62:52]})) - 13'sd1023;
            mant = {1'b1, w[51:0]};
            zero = (w[62:52] == 11'h7FF);
         end
         default: err = 1'b1;
      endcase
      // value = mant*2^(e-52); |x| >= 1 saturates, |x| < 2^-15 gives zero
      if (is_float && !zero) begin
         if (e >= 0) begin
            if (sgn) neg1 = 1'b1; else sat1 = 1'b1;
         end else if (e < -15) begin
            zero = 1'b1;
         end else begin
            shift = 6'(13'sd37 - e);
         end
      end
      // exact mant * 32767
      prod = {mant, 15'd0} - {15'd0, mant};
   end

   // stage 2 combinational
   logic        norm, up;
   logic [67:0] pn;
   logic [53:0] kr, mag;
   logic [5:0]  sh;
   logic [15:0] fres, pcm2;
   always_comb begin
      // round to 53 significant bits, nearest even, then truncate
      norm = !s1_prod_ff[67];
      pn = norm ? {s1_prod_ff[66:0], 1'b0} : s1_prod_ff;
      up = pn[14] && ((|pn[13:0]) || pn[15]);
      kr = {1'b0, pn[67:15]} + {53'd0, up};
      sh = s1_shift_ff + {5'd0, norm};
      mag = kr >> sh;
      fres = s1_sign_ff ? 16'(16'd0 - mag[15:0]) : mag[15:0];
      if (!s1_is_float_ff) pcm2 = s1_int_ff;
      else if (s1_zero_ff) pcm2 = 16'h0000;
      else if (s1_neg1_ff) pcm2 = 16'h8000;
      else if (s1_sat_ff) pcm2 = 16'h7FFF;
      else pcm2 = fres;
      if (s1_err_ff) pcm2 = 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_is_float_ff <= is_float;
         s1_err_ff <= err;
         s1_zero_ff <= zero;
         s1_neg1_ff <= neg1;
         s1_sat_ff <= sat1;
         s1_sign_ff <= sgn;
         s1_int_ff <= int_res;
         s1_chan_ff <= job.channel_index;
         s1_prod_ff <= prod;
         s1_shift_ff <= shift;
         s2_err_ff <= s1_err_ff;
         s2_pcm_ff <= pcm2;
         s2_chan_ff <= s1_chan_ff;
         out_ff.pcm_sample <= s2_pcm_ff;
         out_ff.channel_index <= s2_chan_ff;
         out_ff.status <= s2_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= job_valid;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_ff;
endmodule

// ===== sv/wav_pcm_stream_to_pcm16_unit.sv =====
// wav pcm data chunk to signed 16-bit samples
// req channel: one data byte per word, chunk_end set on the chunk's last byte.
// rsp channel: one word per completed sample with pcm_sample, channel_index and
// status (1 when the format/bit depth is unsupported, sample then 0).
// csr port: write-only, index 0..4 = format kind, container size in bits,
// significant bits, channel count, frame bytes; write only while idle.
// throughput: one byte per cycle while req_stall is low; the frame/sample
// counters in the front advance per byte; the back is a three-stage pipeline.
// a four-word queue sits between the front and the converter pipeline;
// when rsp_stall holds, the pipeline freezes and the queue fills, and
// req_stall rises only once the queue is full.
// reset (synchronous) clears the counters, queue and pipeline and restores
// the register defaults: integer, 16/16 bits, 2 channels, 4-byte frames.
module wav_pcm_stream_to_pcm16_unit #(
   parameter int MaxSampleBytes = wpcm_pkg::MAX_SAMPLE_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wpcm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wpcm_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic [wpcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [wpcm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   logic [1:0]  format_kind_ff;
   logic [6:0]  container_bits_ff, sig_bits_ff;
   logic [15:0] channel_count_ff, frame_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_kind_ff <= 2'd0;
         container_bits_ff <= 7'd16;
         sig_bits_ff <= 7'd16;
         channel_count_ff <= 16'd2;
         frame_bytes_ff <= 16'd4;
      end else if (csr_write) begin
         case (csr_index)
            wpcm_pkg::CSR_FORMAT_KIND:    format_kind_ff <= csr_data[1:0];
            wpcm_pkg::CSR_CONTAINER_BITS: container_bits_ff <= csr_data[6:0];
            wpcm_pkg::CSR_SIG_BITS:       sig_bits_ff <= csr_data[6:0];
            wpcm_pkg::CSR_CHANNEL_COUNT:  channel_count_ff <= csr_data;
            wpcm_pkg::CSR_FRAME_BYTES:    frame_bytes_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic              full, take, push, q_valid, q_pop;
   wpcm_pkg::job_type push_job, q_job;

   assign req_stall = full;
   assign take = req_valid && !full;

   wpcm_front #(.MaxSampleBytes(MaxSampleBytes)) u_front (
      .clock(clock), .reset(reset), .take(take), .req_word(req_word),
      .format_kind(format_kind_ff), .container_bits(container_bits_ff),
      .sig_bits(sig_bits_ff), .channel_count(channel_count_ff),
      .frame_bytes(frame_bytes_ff), .job_valid(push), .job(push_job)
   );

   wpcm_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .full(full), .pop_valid(q_valid), .pop_job(q_job), .pop(q_pop)
   );

   wpcm_back u_back (
      .clock(clock), .reset(reset), .job_valid(q_valid), .job(q_job),
      .job_pop(q_pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );
endmodule
